>>> sv/fgs_pkg.sv
`default_nettype none

package fgs_pkg;

    // result status codes
    localparam logic [1:0] STATUS_NO_MAP      = 2'd0;
    localparam logic [1:0] STATUS_NO_FRONTIER = 2'd1;
    localparam logic [1:0] STATUS_TOO_CLOSE   = 2'd2;
    localparam logic [1:0] STATUS_PUBLISHED   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_GRID_WIDTH     = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE      = 3'd2;
    localparam logic [2:0] REG_ORIGIN_X       = 3'd3;
    localparam logic [2:0] REG_ORIGIN_Y       = 3'd4;
    localparam logic [2:0] REG_GOAL_NUDGE     = 3'd5;
    localparam logic [2:0] REG_MIN_SEPARATION = 3'd6;

    // item kind in s_tuser[0]
    localparam logic MODE_CELL_WRITE = 1'b0;
    localparam logic MODE_TICK       = 1'b1;

    localparam logic [7:0] CELL_FREE    = 8'h00;
    localparam logic [7:0] CELL_UNKNOWN = 8'hFF;

    localparam logic [12:0] COUNT_MAX = 13'h1FFF;

    // clamp a wide signed sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/frontier_goal_selector_core.sv
// Frontier goal selector.
// Input channel (s_*): one item per handshake. s_tuser[0] = mode (0 cell write, 1 tick),
// s_tuser[1] = start_of_map, s_tdata[7:0] = signed occupancy value.
// Cell writes fill the grid memory in row-major order, one item per cycle while the block is
// idle; they make no result. A tick scans the map and returns exactly one result item on m_*.
// Config channel (cfg_*): always ready; write registers only while the block is idle.
// Tick phases, w x h the map size and n the number of frontier cells found:
//   scan       (w-2) * (h-2) interior cells, 9 reads of the single grid read port per cell
//   clustering one frontier list read per cycle over all n x n pairs
//   goal math  one shared 32x32 multiplier, five products in turn
// A tick before the map is complete, or on a map smaller than 3x3, returns without a scan.
// Reset: map not ready, write address zero, no last goal, config at its reset values.
// The grid and frontier memories are not cleared; unwritten cells are never read.
// The result sits in an output register: cell writes keep being accepted while it waits.
// A following tick is processed but holds in its last state until m_tready drains the
// previous result.
`default_nettype none

module frontier_goal_selector_core
    import fgs_pkg::*;
#(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int MAX_FRONTIERS = 4096,
    parameter int TILE          = 5
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] cell_value
    input  wire logic [1:0]  s_tuser,   // [0] mode, [1] start_of_map
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // [7:0] cell_x, [15:8] cell_y, [28:16] cluster_count,
                                        // [60:29] goal_x, [92:61] goal_y, [93] list_overflow
    output logic [1:0]       m_tuser,   // [1:0] status
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int WCW  = $clog2(MAX_WIDTH + 1);
    localparam int HCW  = $clog2(MAX_HEIGHT + 1);
    localparam int GRID = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = $clog2(GRID);
    localparam int NW   = $clog2(GRID + 1);
    localparam int LW   = $clog2(MAX_FRONTIERS);
    localparam int NFW  = $clog2(MAX_FRONTIERS + 1);
    localparam int DW0  = (XW > YW) ? XW : YW;
    localparam int DW   = ((DW0 > 7) ? DW0 : 7) + 1;
    localparam logic [3:0] NB_LAST = 4'd9;   // 9 reads per cell, data of the last at 9

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_FETCH, ST_LOAD, ST_COUNT,
        ST_HX, ST_HY, ST_DX, ST_DY, ST_SQ1, ST_SQ2, ST_CMP, ST_OUT
    } state_t;

    state_t state_reg;

    // config
    logic [8:0]         grid_width_reg, grid_height_reg;
    logic [31:0]        cell_size_reg;
    logic signed [31:0] origin_x_reg, origin_y_reg, nudge_reg;
    logic [30:0]        min_sep_reg;

    // map load
    logic [NW-1:0] wa_reg;
    logic          map_ready_reg;

    // scan
    logic [XW-1:0]  x_reg;
    logic [YW-1:0]  y_reg;
    logic [AW-1:0]  center_reg;
    logic [3:0]     nb_reg;
    logic           center_free_reg, unk_reg, ovf_reg;
    logic [NFW-1:0] n_reg;

    // clustering
    logic [NFW-1:0] i_reg, jcnt_reg, c_reg, best_cnt_reg;
    logic           pend_reg;
    logic [XW-1:0]  xi_reg, bx_reg;
    logic [YW-1:0]  yi_reg, by_reg;

    // goal math
    logic [63:0]        prod_reg, acc_reg;
    logic signed [31:0] gx_reg, gy_reg;
    logic [31:0]        ax_reg, ay_reg;
    logic               last_valid_reg;
    logic signed [31:0] last_x_reg, last_y_reg;

    // pending result and output register
    logic [1:0]  res_status_reg;
    logic [93:0] res_data_reg;
    logic        m_tvalid_reg;
    logic [1:0]  m_tuser_reg;
    logic [93:0] m_data_reg;

    // memories
    logic [7:0]         grid_mem [GRID];
    logic [7:0]         grid_q;
    logic [AW-1:0]      grid_ra;
    logic               grid_we;
    logic [XW+YW-1:0]   list_mem [MAX_FRONTIERS];
    logic [XW+YW-1:0]   list_q;
    logic [LW-1:0]      list_ra;
    logic               list_we;

    // ---------------------------------------------------------------- derived values
    logic [WCW-1:0] eff_w;
    logic [HCW-1:0] eff_h;
    logic [NW-1:0]  needed, wa_base, wa_after;
    logic           s_acc, cell_acc, wr_ok;
    logic [AW-1:0]  w_a;
    logic           is_frontier, last_col, last_row;
    logic [XW-1:0]  xj, dx;
    logic [YW-1:0]  yj, dy;
    logic           near;
    logic [31:0]    mul_a, mul_b;
    logic [63:0]    mul_p, half;
    logic signed [65:0] half_s, sum_x, sum_y;
    logic signed [32:0] dif;
    logic [31:0]    dif_abs;
    logic           close;
    logic [12:0]    cnt_out;

    assign eff_w = (32'(grid_width_reg) > MAX_WIDTH) ? WCW'(MAX_WIDTH) : WCW'(grid_width_reg);
    assign eff_h = (32'(grid_height_reg) > MAX_HEIGHT) ? HCW'(MAX_HEIGHT)
                                                       : HCW'(grid_height_reg);
    assign needed = NW'(NW'(eff_w) * NW'(eff_h));

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign cell_acc = s_acc && (s_tuser[0] == MODE_CELL_WRITE);
    assign wa_base  = s_tuser[1] ? '0 : wa_reg;
    assign wr_ok    = (wa_base < needed);
    assign wa_after = wr_ok ? wa_base + NW'(1) : wa_base;
    assign grid_we  = cell_acc && wr_ok;

    // neighbor address of the current read
    assign w_a = AW'(eff_w);
    always_comb begin
        unique case (nb_reg)
            4'd1:    grid_ra = center_reg - w_a - AW'(1);
            4'd2:    grid_ra = center_reg - w_a;
            4'd3:    grid_ra = center_reg - w_a + AW'(1);
            4'd4:    grid_ra = center_reg - AW'(1);
            4'd5:    grid_ra = center_reg + AW'(1);
            4'd6:    grid_ra = center_reg + w_a - AW'(1);
            4'd7:    grid_ra = center_reg + w_a;
            4'd8:    grid_ra = center_reg + w_a + AW'(1);
            default: grid_ra = center_reg;
        endcase
    end

    assign is_frontier = center_free_reg && (unk_reg || (grid_q == CELL_UNKNOWN));
    assign last_col    = (32'(x_reg) + 2 == 32'(eff_w));
    assign last_row    = (32'(y_reg) + 2 == 32'(eff_h));
    assign list_we     = (state_reg == ST_SCAN) && (nb_reg == NB_LAST) && is_frontier
                         && (n_reg < NFW'(MAX_FRONTIERS));
    assign list_ra     = (state_reg == ST_FETCH) ? i_reg[LW-1:0] : jcnt_reg[LW-1:0];

    // Chebyshev window test against the cell under count
    assign xj   = list_q[XW-1:0];
    assign yj   = list_q[XW +: YW];
    assign dx   = (xi_reg >= xj) ? xi_reg - xj : xj - xi_reg;
    assign dy   = (yi_reg >= yj) ? yi_reg - yj : yj - yi_reg;
    assign near = (DW'(dx) <= DW'(TILE)) && (DW'(dy) <= DW'(TILE));

    // shared multiplier
    always_comb begin
        unique case (state_reg)
            ST_HX:   begin mul_a = 32'({bx_reg, 1'b1}); mul_b = cell_size_reg;      end
            ST_HY:   begin mul_a = 32'({by_reg, 1'b1}); mul_b = cell_size_reg;      end
            ST_DY:   begin mul_a = 32'(ax_reg[30:0]);   mul_b = 32'(ax_reg[30:0]);  end
            ST_SQ1:  begin mul_a = 32'(ay_reg[30:0]);   mul_b = 32'(ay_reg[30:0]);  end
            ST_SQ2:  begin mul_a = 32'(min_sep_reg);    mul_b = 32'(min_sep_reg);   end
            default: begin mul_a = '0;                  mul_b = '0;                 end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // half cell rounded up, then origin and offsets
    assign half   = (prod_reg + 64'd1) >> 1;
    assign half_s = $signed({2'b00, half});
    assign sum_x  = 66'(origin_x_reg) + half_s + 66'(nudge_reg);
    assign sum_y  = 66'(origin_y_reg) + half_s;

    assign dif     = (state_reg == ST_DX) ? 33'(gx_reg) - 33'(last_x_reg)
                                          : 33'(gy_reg) - 33'(last_y_reg);
    assign dif_abs = dif[32] ? 32'(-dif) : dif[31:0];

    assign close = last_valid_reg && !ax_reg[31] && !ay_reg[31] && (acc_reg < prod_reg);
    assign cnt_out = (32'(best_cnt_reg) > 32'(COUNT_MAX)) ? COUNT_MAX : 13'(best_cnt_reg);

    // ---------------------------------------------------------------- memories
    always_ff @(posedge aclk) begin
        if (grid_we) begin
            grid_mem[wa_base[AW-1:0]] <= s_tdata;
        end
        grid_q <= grid_mem[grid_ra];
    end

    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[n_reg[LW-1:0]] <= {y_reg, x_reg};
        end
        list_q <= list_mem[list_ra];
    end

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= 9'd256;
            grid_height_reg <= 9'd256;
            cell_size_reg   <= 32'd3277;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            nudge_reg       <= '0;
            min_sep_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_GRID_WIDTH:     grid_width_reg  <= cfg_data[8:0];
                REG_GRID_HEIGHT:    grid_height_reg <= cfg_data[8:0];
                REG_CELL_SIZE:      cell_size_reg   <= cfg_data;
                REG_ORIGIN_X:       origin_x_reg    <= cfg_data;
                REG_ORIGIN_Y:       origin_y_reg    <= cfg_data;
                REG_GOAL_NUDGE:     nudge_reg       <= cfg_data;
                REG_MIN_SEPARATION: min_sep_reg     <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wa_reg         <= '0;
            map_ready_reg  <= 1'b0;
            last_valid_reg <= 1'b0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // ST_OUT reloads the register itself when it drains
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cell_acc) begin
                        wa_reg        <= wa_after;
                        map_ready_reg <= (wa_after >= needed);
                    end else if (s_acc) begin
                        res_data_reg <= '0;
                        if (!map_ready_reg) begin
                            res_status_reg <= STATUS_NO_MAP;
                            state_reg      <= ST_OUT;
                        end else if (32'(eff_w) < 3 || 32'(eff_h) < 3) begin
                            res_status_reg <= STATUS_NO_FRONTIER;
                            state_reg      <= ST_OUT;
                        end else begin
                            x_reg      <= XW'(1);
                            y_reg      <= YW'(1);
                            center_reg <= w_a + AW'(1);
                            nb_reg     <= '0;
                            unk_reg    <= 1'b0;
                            ovf_reg    <= 1'b0;
                            n_reg      <= '0;
                            state_reg  <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // read k issued at nb = k, its data seen at nb = k + 1
                    if (nb_reg == 4'd1) begin
                        center_free_reg <= (grid_q == CELL_FREE);
                    end else if (nb_reg > 4'd1 && nb_reg < NB_LAST
                                 && grid_q == CELL_UNKNOWN) begin
                        unk_reg <= 1'b1;
                    end
                    if (nb_reg == NB_LAST) begin
                        nb_reg  <= '0;
                        unk_reg <= 1'b0;
                        if (list_we) begin
                            n_reg <= n_reg + NFW'(1);
                        end else if (is_frontier) begin
                            ovf_reg <= 1'b1;
                        end
                        if (last_col) begin
                            x_reg      <= XW'(1);
                            y_reg      <= y_reg + YW'(1);
                            center_reg <= center_reg + AW'(3);
                            if (last_row) begin
                                if (n_reg == '0 && !list_we) begin
                                    res_status_reg <= STATUS_NO_FRONTIER;
                                    state_reg      <= ST_OUT;
                                end else begin
                                    i_reg        <= '0;
                                    best_cnt_reg <= '0;
                                    state_reg    <= ST_FETCH;
                                end
                            end
                        end else begin
                            x_reg      <= x_reg + XW'(1);
                            center_reg <= center_reg + AW'(1);
                        end
                    end else begin
                        nb_reg <= nb_reg + 4'd1;
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    xi_reg    <= list_q[XW-1:0];
                    yi_reg    <= list_q[XW +: YW];
                    jcnt_reg  <= '0;
                    pend_reg  <= 1'b0;
                    c_reg     <= '0;
                    state_reg <= ST_COUNT;
                end
                ST_COUNT: begin
                    if (jcnt_reg < n_reg) begin
                        jcnt_reg <= jcnt_reg + NFW'(1);
                        pend_reg <= 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg && near) begin
                        c_reg <= c_reg + NFW'(1);
                    end
                    if (jcnt_reg == n_reg && !pend_reg) begin
                        // first strictly greater count wins
                        if (c_reg > best_cnt_reg) begin
                            best_cnt_reg <= c_reg;
                            bx_reg       <= xi_reg;
                            by_reg       <= yi_reg;
                        end
                        if (i_reg + NFW'(1) == n_reg) begin
                            state_reg <= ST_HX;
                        end else begin
                            i_reg     <= i_reg + NFW'(1);
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_HX: begin
                    state_reg <= ST_HY;
                end
                ST_HY: begin
                    gx_reg    <= sat32(sum_x);
                    state_reg <= ST_DX;
                end
                ST_DX: begin
                    gy_reg    <= sat32(sum_y);
                    ax_reg    <= dif_abs;
                    state_reg <= ST_DY;
                end
                ST_DY: begin
                    ay_reg    <= dif_abs;
                    state_reg <= ST_SQ1;
                end
                ST_SQ1: begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_SQ2;
                end
                ST_SQ2: begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    res_data_reg <= {ovf_reg, gy_reg, gx_reg, cnt_out,
                                     8'(by_reg), 8'(bx_reg)};
                    if (close) begin
                        res_status_reg <= STATUS_TOO_CLOSE;
                    end else begin
                        res_status_reg <= STATUS_PUBLISHED;
                        last_valid_reg <= 1'b1;
                        last_x_reg     <= gx_reg;
                        last_y_reg     <= gy_reg;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_data_reg   <= res_data_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = {2'b00, m_data_reg};

endmodule

`default_nettype wire

>>> tb/fgs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fgs_checker
    import fgs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [95:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               mismatches,
    output int               open_goals,
    output int               goals_seen
);

    localparam int GRID_DIM   = 256;
    localparam int LIST_DEPTH = 4096;
    localparam int WINDOW     = 5;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic [12:0] cluster;
        logic [31:0] goal_x;
        logic [31:0] goal_y;
        logic        overflow;
    } goal_result_t;

    goal_result_t goal_q[$];

    logic [7:0]  grid [GRID_DIM*GRID_DIM];
    logic [8:0]  width_reg, height_reg;
    logic [31:0] cell_size, origin_x, origin_y, nudge;
    logic [30:0] min_sep;
    int unsigned wr_addr;
    bit          map_ready, have_last;
    longint      last_x, last_y;

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint half_cell_q16(input int unsigned c);
        longint unsigned p;
        p = (2 * longint'(c) + 1) * longint'(cell_size);
        return longint'((p + 1) >> 1);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // replan: frontier scan, densest cluster, goal position, separation test
    task automatic plan_goal();
        int unsigned  w, h, x, y, c, best, best_cnt;
        int           fx[$], fy[$];
        int           dx, dy, ddx, ddy;
        bit           frontier;
        longint       gx, gy;
        longint unsigned ax, ay, sep;
        goal_result_t r;
        r = '{STATUS_NO_MAP, 8'd0, 8'd0, 13'd0, 32'd0, 32'd0, 1'b0};
        if (!map_ready) begin
            goal_q.push_back(r);
            return;
        end
        r.status = STATUS_NO_FRONTIER;
        w = (width_reg > GRID_DIM) ? GRID_DIM : width_reg;
        h = (height_reg > GRID_DIM) ? GRID_DIM : height_reg;
        for (y = 1; y + 1 < h; y++) begin
            for (x = 1; x + 1 < w; x++) begin
                if (grid[y*w + x] == CELL_FREE) begin
                    frontier = 0;
                    for (dy = -1; dy <= 1; dy++)
                        for (dx = -1; dx <= 1; dx++)
                            if ((dx != 0 || dy != 0) &&
                                grid[(int'(y) + dy)*w + int'(x) + dx] == CELL_UNKNOWN)
                                frontier = 1;
                    if (frontier) begin
                        if (fx.size() < LIST_DEPTH) begin
                            fx.push_back(x);
                            fy.push_back(y);
                        end else begin
                            r.overflow = 1'b1;
                        end
                    end
                end
            end
        end
        if (fx.size() == 0) begin
            r.overflow = 1'b0;
            goal_q.push_back(r);
            return;
        end
        best = 0;
        best_cnt = 0;
        for (int i = 0; i < fx.size(); i++) begin
            c = 0;
            for (int j = 0; j < fx.size(); j++) begin
                ddx = fx[i] - fx[j];
                ddy = fy[i] - fy[j];
                if (ddx < 0) ddx = -ddx;
                if (ddy < 0) ddy = -ddy;
                if (ddx <= WINDOW && ddy <= WINDOW) c++;
            end
            if (c > best_cnt) begin
                best_cnt = c;
                best = i;
            end
        end
        gx = clamp_s32(longint'($signed(origin_x)) + half_cell_q16(fx[best]) +
                       longint'($signed(nudge)));
        gy = clamp_s32(longint'($signed(origin_y)) + half_cell_q16(fy[best]));
        r.cell_x  = fx[best][7:0];
        r.cell_y  = fy[best][7:0];
        r.cluster = (best_cnt > COUNT_MAX) ? COUNT_MAX : best_cnt[12:0];
        r.goal_x  = gx[31:0];
        r.goal_y  = gy[31:0];
        r.status  = STATUS_PUBLISHED;
        if (have_last) begin
            ax  = (gx > last_x) ? longint'(gx - last_x) : longint'(last_x - gx);
            ay  = (gy > last_y) ? longint'(gy - last_y) : longint'(last_y - gy);
            sep = min_sep;
            if (ax < 64'h8000_0000 && ay < 64'h8000_0000 && ax*ax + ay*ay < sep*sep)
                r.status = STATUS_TOO_CLOSE;
        end
        if (r.status == STATUS_PUBLISHED) begin
            have_last = 1;
            last_x = gx;
            last_y = gy;
        end
        goal_q.push_back(r);
    endtask

    task automatic store_cell(input logic start, input logic [7:0] v);
        int unsigned needed;
        needed = ((width_reg > GRID_DIM) ? GRID_DIM : width_reg) *
                 ((height_reg > GRID_DIM) ? GRID_DIM : height_reg);
        if (start) begin
            wr_addr = 0;
            map_ready = 0;
        end
        if (wr_addr < needed) begin
            grid[wr_addr] = v;
            wr_addr++;
        end
        if (wr_addr >= needed) map_ready = 1;
    endtask

    always @(posedge aclk) begin
        goal_result_t e;
        if (!aresetn) begin
            goal_q.delete();
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            cell_size  <= 32'd3277;
            origin_x   <= '0;
            origin_y   <= '0;
            nudge      <= '0;
            min_sep    <= '0;
            wr_addr    = 0;
            map_ready  = 0;
            have_last  = 0;
            last_x     = 0;
            last_y     = 0;
            mismatches = 0;
            open_goals <= 0;
            goals_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GRID_WIDTH:     width_reg  <= cfg_data[8:0];
                    REG_GRID_HEIGHT:    height_reg <= cfg_data[8:0];
                    REG_CELL_SIZE:      cell_size  <= cfg_data;
                    REG_ORIGIN_X:       origin_x   <= cfg_data;
                    REG_ORIGIN_Y:       origin_y   <= cfg_data;
                    REG_GOAL_NUDGE:     nudge      <= cfg_data;
                    REG_MIN_SEPARATION: min_sep    <= cfg_data[30:0];
                    default: ;
                endcase
            end
            // results first so the front of the queue is always the oldest tick
            if (m_tvalid && m_tready) begin
                goals_seen <= goals_seen + 1;
                if (goal_q.size() == 0) begin
                    report_mismatch("unexpected result", {30'd0, m_tuser}, 32'd0);
                end else begin
                    e = goal_q.pop_front();
                    check_field("status", {30'd0, m_tuser}, {30'd0, e.status});
                    check_field("cell_x", {24'd0, m_tdata[7:0]}, {24'd0, e.cell_x});
                    check_field("cell_y", {24'd0, m_tdata[15:8]}, {24'd0, e.cell_y});
                    check_field("cluster_count", {19'd0, m_tdata[28:16]},
                                {19'd0, e.cluster});
                    check_field("goal_x", m_tdata[60:29], e.goal_x);
                    check_field("goal_y", m_tdata[92:61], e.goal_y);
                    check_field("list_overflow", {31'd0, m_tdata[93]}, {31'd0, e.overflow});
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == MODE_TICK) plan_goal();
                else store_cell(s_tuser[1], s_tdata);
            end
            open_goals <= goal_q.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import fgs_pkg::*;

    // no-progress limit: covers the clustering of a 256x3 tick, plus stalls
    localparam int STALL_LIMIT = 400000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] cell_value
    logic [1:0]  s_tuser   = '0;   // [0] mode, [1] start_of_map
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;          // [7:0] x, [15:8] y, [28:16] count, [60:29] gx,
                                   // [92:61] gy, [93] overflow
    logic [1:0]  m_tuser;          // [1:0] status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    int mismatches, open_goals, goals_seen;
    int items;
    int send_idle_pct, stall_pct;
    int no_progress = 0;
    int phase_items, phase_goals;
    logic [8:0] map_w, map_h;

    frontier_goal_selector_core uut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    fgs_checker u_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .mismatches, .open_goals, .goals_seen
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure
    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // watchdog: any accepted item or register write counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            no_progress <= 0;
        else
            no_progress <= no_progress + 1;
        if (no_progress >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // one item on the input channel; returns at the accepting edge
    task automatic send_item(input logic mode, input logic start, input logic [7:0] v);
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {start, mode};
        s_tdata  <= v;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        items++;
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, 1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    // mostly free, a good share unknown, some occupied
    function automatic logic [7:0] rand_cell();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return CELL_FREE;
            5, 6, 7:       return CELL_UNKNOWN;
            8:             return 8'($urandom);
            default:       return 8'd1;
        endcase
    endfunction

    // quiet the input side and let every pending tick drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (open_goals != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // caller has settled; consecutive writes keep cfg_valid high
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_dims(input logic [8:0] w, input logic [8:0] h);
        map_w = w;
        map_h = h;
        write_reg(REG_GRID_WIDTH, {23'd0, w});
        write_reg(REG_GRID_HEIGHT, {23'd0, h});
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return $urandom_range(0, 20 << 16);
            2:       return -$urandom_range(0, 20 << 16);
            3:       return $urandom;
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // full map of random content under the current dimensions
    task automatic send_map();
        int unsigned w, h;
        w = (map_w > 256) ? 256 : map_w;
        h = (map_h > 256) ? 256 : map_h;
        if (w * h == 0) begin
            send_item(MODE_CELL_WRITE, 1'b1, rand_cell());
            return;
        end
        for (int unsigned a = 0; a < w * h; a++) begin
            send_item(MODE_CELL_WRITE, a == 0, rand_cell());
            // an early tick sees no map yet
            if ($urandom_range(0, 199) == 0) send_tick();
        end
    endtask

    initial begin
        send_idle_pct = 0;
        stall_pct     = 0;
        items         = 0;
        map_w         = 9'd256;
        map_h         = 9'd256;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed ----
        send_tick();                                   // before any map
        settle();
        set_dims(9'd4, 9'd3);
        write_reg(REG_CELL_SIZE, 32'd3277);
        write_reg(REG_ORIGIN_X, 32'hFFFF_0000);
        write_reg(REG_ORIGIN_Y, 32'h0001_8000);
        write_reg(REG_GOAL_NUDGE, 32'h0000_4000);
        write_reg(REG_MIN_SEPARATION, 32'd0);
        // 4x3: unknown cells on the border, two free interior cells -> frontier
        send_item(MODE_CELL_WRITE, 1'b1, CELL_UNKNOWN);
        send_item(MODE_CELL_WRITE, 1'b0, 8'h80);
        send_item(MODE_CELL_WRITE, 1'b0, 8'h7F);
        send_item(MODE_CELL_WRITE, 1'b0, CELL_UNKNOWN);
        send_item(MODE_CELL_WRITE, 1'b0, CELL_UNKNOWN);
        send_item(MODE_CELL_WRITE, 1'b0, CELL_FREE);
        send_item(MODE_CELL_WRITE, 1'b0, CELL_FREE);
        send_item(MODE_CELL_WRITE, 1'b0, 8'h01);
        for (int i = 0; i < 4; i++) send_item(MODE_CELL_WRITE, 1'b0, CELL_FREE);
        send_item(MODE_CELL_WRITE, 1'b0, CELL_UNKNOWN);  // extra, ignored
        send_tick();                                     // published
        send_tick();                                     // zero separation: published again
        settle();
        write_reg(REG_MIN_SEPARATION, 32'h7FFF_FFFF);
        send_tick();                                     // too close
        send_item(MODE_CELL_WRITE, 1'b1, CELL_UNKNOWN);  // restart drops the map
        send_tick();
        settle();
        // saturation both ways
        write_reg(REG_CELL_SIZE, 32'hFFFF_FFFF);
        write_reg(REG_ORIGIN_X, 32'h7FFF_FFFF);
        write_reg(REG_ORIGIN_Y, 32'h8000_0000);
        write_reg(REG_GOAL_NUDGE, 32'h7FFF_FFFF);
        write_reg(REG_MIN_SEPARATION, 32'd0);
        send_map();
        send_tick();
        settle();
        write_reg(REG_GOAL_NUDGE, 32'h8000_0000);
        write_reg(REG_CELL_SIZE, 32'd0);
        write_reg(REG_ORIGIN_X, 32'h8000_0000);
        set_dims(9'd0, 9'd5);                            // zero-cell map
        send_map();
        send_tick();
        settle();
        set_dims(9'd2, 9'd5);                            // too narrow
        send_map();
        send_tick();
        settle();
        set_dims(9'd511, 9'd3);                          // clamped to full width
        write_reg(REG_CELL_SIZE, 32'd3277);
        send_map();
        send_tick();
        settle();
        set_dims(9'd3, 9'd40);
        send_map();
        send_tick();
        settle();

        // ---- random, four back-pressure phases ----
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            phase_items = items;
            phase_goals = goals_seen;
            while (items < phase_items + 160 || goals_seen < phase_goals + 6) begin
                if ($urandom_range(0, 1)) begin
                    settle();
                    set_dims($urandom_range(0, 19) == 0 ? 9'($urandom_range(0, 511))
                                                        : 9'($urandom_range(1, 12)),
                             $urandom_range(0, 9) == 0 ? 9'($urandom_range(0, 2))
                                                       : 9'($urandom_range(3, 10)));
                    // keep the rare oversize draw small in the other dimension
                    if (map_w > 14) set_dims(map_w, 9'($urandom_range(0, 2)));
                    if ($urandom_range(0, 2) == 0) begin
                        write_reg(REG_CELL_SIZE, $urandom_range(0, 3) == 0 ? $urandom
                                                                            : 32'd3277);
                        write_reg(REG_ORIGIN_X, rand_q16());
                        write_reg(REG_ORIGIN_Y, rand_q16());
                        write_reg(REG_GOAL_NUDGE, rand_q16());
                    end
                    if ($urandom_range(0, 1))
                        write_reg(REG_MIN_SEPARATION, $urandom_range(0, 3) == 0
                                  ? ($urandom & 32'h7FFF_FFFF)
                                  : $urandom_range(0, 4 * 3277));
                end
                if ($urandom_range(0, 9) == 0) begin
                    // broken map: partial fill then restart
                    send_item(MODE_CELL_WRITE, 1'b1, rand_cell());
                    repeat ($urandom_range(0, 5))
                        send_item(MODE_CELL_WRITE, 1'b0, 8'($urandom));
                    send_tick();
                end
                send_map();
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 4))
                        send_item(MODE_CELL_WRITE, 1'b0, 8'($urandom));
                repeat ($urandom_range(1, 3)) send_tick();
            end
        end

        settle();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && open_goals == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
sv/fgs_pkg.sv
sv/frontier_goal_selector_core.sv
tb/fgs_checker.sv
tb/tb_top.sv
